>>> rtl/tcte_pkg.sv
`default_nettype none

package tcte_pkg;

    localparam int TCTE_MAX_COLS = 80;
    localparam int TCTE_MAX_ROWS = 25;

    // control characters seen by teletype output
    localparam logic [7:0] TCTE_CH_NUL = 8'h00;
    localparam logic [7:0] TCTE_CH_BEL = 8'h07;
    localparam logic [7:0] TCTE_CH_BS  = 8'h08;
    localparam logic [7:0] TCTE_CH_LF  = 8'h0A;
    localparam logic [7:0] TCTE_CH_CR  = 8'h0D;
    localparam logic [7:0] TCTE_BLANK  = 8'h20;
    localparam logic [7:0] TCTE_ATTR_DEFAULT = 8'h07;

    // operation codes
    localparam logic [2:0] TCTE_F_TTY    = 3'd0;
    localparam logic [2:0] TCTE_F_WRCA   = 3'd1;
    localparam logic [2:0] TCTE_F_WRC    = 3'd2;
    localparam logic [2:0] TCTE_F_SCRUP  = 3'd3;
    localparam logic [2:0] TCTE_F_SCRDN  = 3'd4;
    localparam logic [2:0] TCTE_F_SETCUR = 3'd5;
    localparam logic [2:0] TCTE_F_READ   = 3'd6;

    // configuration register indexes
    localparam logic TCTE_REG_COLS = 1'b0;
    localparam logic TCTE_REG_ROWS = 1'b1;

endpackage

`default_nettype wire

>>> rtl/text_console_teletype_engine.sv
`default_nettype none

// Text console engine: a cell store of 16-bit words (character in the low byte,
// attribute in the high byte) at row * columns + column, plus a cursor. An
// operation is taken when start is high and busy is low; exactly one result
// word follows, shown for one cycle with o_done high, and it cannot be held
// off, so the receiver must take it in that cycle. Right after reset busy
// stays high while every cell is filled with a blank in attribute 07;
// configuration writes are taken during that time. The cell memory has one
// write port and one registered read port: a write with attribute writes
// each cell straight in, a write without attribute reads each cell first; a
// scroll reads each moved cell and writes it, or writes a blank, over the
// whole window rows; a rectangle clear writes each cell; a teletype character
// that scrolls the screen moves every cell up a row and blanks the bottom
// row. Each operation first runs setup states M0 to M3 on a shared
// multiplier. The user must write configuration only while idle; the block
// itself does not enforce it.
module text_console_teletype_engine
    import tcte_pkg::*;
#(
    parameter int MAX_COLS = TCTE_MAX_COLS,
    parameter int MAX_ROWS = TCTE_MAX_ROWS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // command side
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_func,
    input  wire logic [7:0] i_char_code,
    input  wire logic [7:0] i_attribute,
    input  wire logic [7:0] i_repeat_count,
    input  wire logic [4:0] i_win_top,
    input  wire logic [6:0] i_win_left,
    input  wire logic [4:0] i_win_bottom,
    input  wire logic [6:0] i_win_right,
    input  wire logic [4:0] i_new_row,
    input  wire logic [6:0] i_new_col,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_wdata,
    // result word
    output logic            o_done,
    output logic      [7:0] o_read_char,
    output logic      [7:0] o_read_attr,
    output logic      [4:0] o_cursor_row,
    output logic      [6:0] o_cursor_col
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    // address arithmetic width, room for sums up to twice the depth
    localparam int PW    = AW + 2;

    // sequencer states
    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_M0    = 5'd2;
    localparam logic [4:0] S_M1    = 5'd3;
    localparam logic [4:0] S_M2    = 5'd4;
    localparam logic [4:0] S_M3    = 5'd5;
    localparam logic [4:0] S_GO    = 5'd6;
    localparam logic [4:0] S_TWR   = 5'd7;
    localparam logic [4:0] S_DOWN  = 5'd8;
    localparam logic [4:0] S_BRRD  = 5'd9;
    localparam logic [4:0] S_BRWT  = 5'd10;
    localparam logic [4:0] S_SCAN  = 5'd11;
    localparam logic [4:0] S_CWR   = 5'd12;
    localparam logic [4:0] S_RECT  = 5'd13;
    localparam logic [4:0] S_WLOOP = 5'd14;
    localparam logic [4:0] S_WRMW  = 5'd15;
    localparam logic [4:0] S_RDWT  = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0]    r_state;
    logic [6:0]    r_cfg_cols;
    logic [4:0]    r_cfg_rows;
    logic [4:0]    r_row;
    logic [6:0]    r_col;

    // latched operation
    logic [2:0]    r_func;
    logic [7:0]    r_ch;
    logic [7:0]    r_attr;
    logic [7:0]    r_n;
    logic [4:0]    r_top;
    logic [4:0]    r_bot;
    logic [6:0]    r_left;
    logic [6:0]    r_right;
    logic [7:0]    r_rc;
    logic [7:0]    r_ra;

    // products from the shared multiplier
    logic [PW-1:0] r_p0;    // first row base (cursor row or window top)
    logic [PW-1:0] r_p1;    // end of window, exclusive
    logic [PW-1:0] r_p2;    // scroll distance in cells
    logic [PW-1:0] r_p3;    // end of screen, exclusive

    // sweep engine
    logic [PW-1:0] r_addr;
    logic [PW-1:0] r_wlo;
    logic [PW-1:0] r_whi;
    logic [PW-1:0] r_off;
    logic          r_dn;
    logic [7:0]    r_cnt;
    logic [PW-1:0] r_base;
    logic [6:0]    r_c;

    logic [6:0]    cols;
    logic [4:0]    rows;
    logic [4:0]    row_sat;
    logic [6:0]    col_sat;
    logic [4:0]    bot_sat;
    logic [6:0]    right_sat;
    logic [7:0]    n_sat;
    logic [4:0]    nrow_sat;
    logic [6:0]    ncol_sat;
    logic          is_scroll;

    logic [5:0]    mul_a;
    logic [PW-1:0] mul_p;

    logic [PW-1:0] cur_addr;
    logic [PW-1:0] up_src;
    logic [PW-1:0] dn_src;
    logic          scan_ok;
    logic          scan_last;
    logic [PW-1:0] rect_addr;

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [PW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    // geometry saturated to 1..MAX
    always_comb begin
        if (r_cfg_cols == 7'd0) begin
            cols = 7'd1;
        end else if (int'(r_cfg_cols) > MAX_COLS) begin
            cols = 7'(MAX_COLS);
        end else begin
            cols = r_cfg_cols;
        end
        if (r_cfg_rows == 5'd0) begin
            rows = 5'd1;
        end else if (int'(r_cfg_rows) > MAX_ROWS) begin
            rows = 5'(MAX_ROWS);
        end else begin
            rows = r_cfg_rows;
        end
    end

    // clamps taken at accept
    assign row_sat   = (r_row >= rows) ? rows - 5'd1 : r_row;
    assign col_sat   = (r_col >= cols) ? cols - 7'd1 : r_col;
    assign bot_sat   = (i_win_bottom >= rows) ? rows - 5'd1 : i_win_bottom;
    assign right_sat = (i_win_right >= cols) ? cols - 7'd1 : i_win_right;
    assign n_sat     = (i_repeat_count > 8'(rows)) ? 8'(rows) : i_repeat_count;
    assign nrow_sat  = (i_new_row >= rows) ? rows - 5'd1 : i_new_row;
    assign ncol_sat  = (i_new_col >= cols) ? cols - 7'd1 : i_new_col;
    assign is_scroll = (r_func == TCTE_F_SCRUP) || (r_func == TCTE_F_SCRDN);

    // shared multiplier operand, one product per setup state
    always_comb begin
        case (r_state)
            S_M0:    mul_a = is_scroll ? 6'(r_top) : 6'(r_row);
            S_M1:    mul_a = 6'(r_bot) + 6'd1;
            S_M2:    mul_a = r_n[5:0];
            default: mul_a = 6'(rows);
        endcase
    end

    tcte_mul #(
        .PW (PW)
    ) u_mul (
        .i_a    (mul_a),
        .i_cols (cols),
        .o_prod (mul_p)
    );

    assign cur_addr  = r_p0 + PW'(r_col);
    assign up_src    = r_addr + r_off;
    assign dn_src    = r_addr - r_off;
    // a moved row exists inside the window, otherwise the cell comes free
    assign scan_ok   = r_dn ? (r_addr >= r_wlo + r_off) : (up_src < r_whi);
    assign scan_last = r_dn ? (r_addr == r_wlo) : (r_addr + PW'(1) == r_whi);
    assign rect_addr = r_base + PW'(r_c);

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {r_attr, TCTE_BLANK};
        mem_raddr = r_addr;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {TCTE_ATTR_DEFAULT, TCTE_BLANK};
            end
            S_GO: begin
                mem_raddr = cur_addr;
            end
            S_TWR: begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {mem_rdata[15:8], r_ch};
            end
            S_BRRD: begin
                mem_raddr = r_p3 - PW'(1);
            end
            S_SCAN: begin
                mem_we    = !scan_ok;
                mem_raddr = r_dn ? dn_src : up_src;
            end
            S_CWR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            S_RECT: begin
                mem_we    = 1'b1;
                mem_waddr = rect_addr;
            end
            S_WLOOP: begin
                // attribute write goes straight in, char-only reads first
                mem_we    = (r_cnt != 8'd0) && (r_addr < r_p3) && (r_func == TCTE_F_WRCA);
                mem_wdata = {r_attr, r_ch};
            end
            S_WRMW: begin
                mem_we    = 1'b1;
                mem_wdata = {mem_rdata[15:8], r_ch};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    tcte_cellmem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= 7'd80;
            r_cfg_rows <= 5'd25;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                TCTE_REG_COLS: r_cfg_cols <= i_cfg_wdata;
                TCTE_REG_ROWS: r_cfg_rows <= i_cfg_wdata[4:0];
                default:       r_cfg_cols <= r_cfg_cols;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_row   <= 5'd0;
            r_col   <= 7'd0;
        end else begin
            case (r_state)
                S_INIT: begin
                    // blank fill of the whole store after reset
                    if (r_addr == PW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_addr <= r_addr + PW'(1);
                end
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_ch    <= i_char_code;
                        r_attr  <= i_attribute;
                        r_n     <= ((i_func == TCTE_F_SCRUP) || (i_func == TCTE_F_SCRDN))
                                   ? n_sat : i_repeat_count;
                        r_top   <= i_win_top;
                        r_bot   <= bot_sat;
                        r_left  <= i_win_left;
                        r_right <= right_sat;
                        r_rc    <= 8'd0;
                        r_ra    <= 8'd0;
                        if (i_func == TCTE_F_SETCUR) begin
                            r_row <= nrow_sat;
                            r_col <= ncol_sat;
                        end else begin
                            r_row <= row_sat;
                            r_col <= col_sat;
                        end
                        r_state <= S_M0;
                    end
                end
                S_M0: begin
                    r_p0    <= mul_p;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p1    <= mul_p;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_p2    <= mul_p;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_p3    <= mul_p;
                    r_state <= S_GO;
                end
                S_GO: begin
                    case (r_func)
                        TCTE_F_TTY: begin
                            if ((r_ch == TCTE_CH_NUL) || (r_ch == TCTE_CH_BEL)) begin
                                r_state <= S_DONE;
                            end else if (r_ch == TCTE_CH_CR) begin
                                r_col   <= 7'd0;
                                r_state <= S_DONE;
                            end else if (r_ch == TCTE_CH_BS) begin
                                if (r_col != 7'd0) begin
                                    r_col <= r_col - 7'd1;
                                end
                                r_state <= S_DONE;
                            end else if (r_ch == TCTE_CH_LF) begin
                                r_state <= S_DOWN;
                            end else begin
                                // cell read issued here, char replaced next
                                r_state <= S_TWR;
                            end
                        end
                        TCTE_F_WRCA, TCTE_F_WRC: begin
                            r_addr  <= cur_addr;
                            r_cnt   <= r_n;
                            r_state <= S_WLOOP;
                        end
                        TCTE_F_SCRUP, TCTE_F_SCRDN: begin
                            if (r_top > r_bot) begin
                                r_state <= S_DONE;
                            end else if (r_n == 8'd0) begin
                                if (r_left > r_right) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_base  <= r_p0;
                                    r_c     <= r_left;
                                    r_state <= S_RECT;
                                end
                            end else begin
                                r_wlo   <= r_p0;
                                r_whi   <= r_p1;
                                r_off   <= r_p2;
                                r_dn    <= (r_func == TCTE_F_SCRDN);
                                r_addr  <= (r_func == TCTE_F_SCRDN) ? r_p1 - PW'(1) : r_p0;
                                r_state <= S_SCAN;
                            end
                        end
                        TCTE_F_READ: begin
                            r_state <= S_RDWT;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_TWR: begin
                    // advance, wrapping to the next row
                    if (r_col + 7'd1 >= cols) begin
                        r_col   <= 7'd0;
                        r_state <= S_DOWN;
                    end else begin
                        r_col   <= r_col + 7'd1;
                        r_state <= S_DONE;
                    end
                end
                S_DOWN: begin
                    if (r_row + 5'd1 < rows) begin
                        r_row   <= r_row + 5'd1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BRRD;
                    end
                end
                S_BRRD: begin
                    r_state <= S_BRWT;
                end
                S_BRWT: begin
                    // full screen scroll up one row, fill in bottom-right attribute
                    r_attr  <= mem_rdata[15:8];
                    r_wlo   <= '0;
                    r_whi   <= r_p3;
                    r_off   <= PW'(cols);
                    r_dn    <= 1'b0;
                    r_addr  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN, S_CWR: begin
                    if ((r_state == S_SCAN) && scan_ok) begin
                        r_state <= S_CWR;
                    end else if (scan_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr  <= r_dn ? r_addr - PW'(1) : r_addr + PW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_RECT: begin
                    if (r_c == r_right) begin
                        if (r_top == r_bot) begin
                            r_state <= S_DONE;
                        end else begin
                            r_top  <= r_top + 5'd1;
                            r_base <= r_base + PW'(cols);
                            r_c    <= r_left;
                        end
                    end else begin
                        r_c <= r_c + 7'd1;
                    end
                end
                S_WLOOP: begin
                    if ((r_cnt == 8'd0) || (r_addr >= r_p3)) begin
                        r_state <= S_DONE;
                    end else if (r_func == TCTE_F_WRCA) begin
                        r_addr <= r_addr + PW'(1);
                        r_cnt  <= r_cnt - 8'd1;
                    end else begin
                        r_state <= S_WRMW;
                    end
                end
                S_WRMW: begin
                    r_addr  <= r_addr + PW'(1);
                    r_cnt   <= r_cnt - 8'd1;
                    r_state <= S_WLOOP;
                end
                S_RDWT: begin
                    r_rc    <= mem_rdata[7:0];
                    r_ra    <= mem_rdata[15:8];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_read_char  = r_rc;
    assign o_read_attr  = r_ra;
    assign o_cursor_row = r_row;
    assign o_cursor_col = r_col;

endmodule

`default_nettype wire

>>> rtl/tcte_mul.sv
`default_nettype none

module tcte_mul
    import tcte_pkg::*;
#(
    parameter int PW = 13
) (
    input  wire logic [5:0]    i_a,
    input  wire logic [6:0]    i_cols,
    output logic      [PW-1:0] o_prod
);

    logic [12:0] prod;

    // row count times row pitch
    assign prod   = 13'(i_a) * 13'(i_cols);
    assign o_prod = PW'(prod);

endmodule

`default_nettype wire

>>> rtl/tcte_cellmem.sv
`default_nettype none

module tcte_cellmem
    import tcte_pkg::*;
#(
    parameter int DEPTH = TCTE_MAX_COLS * TCTE_MAX_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
